// File: hdl/planar_flow_forward_top_defines.svh
// Assertion macros shared by the checker of the planar flow block
`ifndef PLANAR_FLOW_FORWARD_TOP_DEFINES_SVH
`define PLANAR_FLOW_FORWARD_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define PFF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/pff_pkg.sv
// Shared types and constants of the planar flow block
package pff_pkg;

  localparam int unsigned DIMS  = 4;
  localparam int unsigned LANES = 4;
  localparam int unsigned IDX_W = 2;
  localparam int unsigned S_W   = 36;
  localparam int unsigned XQ_W  = 26;
  localparam int unsigned NUM_W = 47;
  localparam int unsigned DEN_W = 32;

  localparam logic [2:0] REG_U_VEC     = 3'd0;
  localparam logic [2:0] REG_W_VEC     = 3'd1;
  localparam logic [2:0] REG_BIAS      = 3'd2;
  localparam logic [2:0] REG_DET_FLOOR = 3'd3;

  typedef struct packed {
    logic [63:0] u_vec;
    logic [63:0] w_vec;
    logic [15:0] bias;
    logic [15:0] det_floor;
  } cfg_t;

  // Classified point handed from front to back
  typedef struct packed {
    logic [LANES-1:0][15:0] x;
    logic [XQ_W-1:0]        xq;   // 2|s|/256 in Q.30
    logic                   neg;  // sign of s
    logic                   sat;  // |2s| >= 16, tanh saturates
    logic                   fin;
  } job_t;

endpackage

// File: hdl/pff_front.sv
// Front end: takes a point, forms s = w.x + b one lane a cycle, classifies it
module pff_front import pff_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  output logic                   full_o,
  input  logic [LANES-1:0][15:0] x_i,
  input  logic                   fin_i,
  input  cfg_t                   cfg_i,
  output logic                   job_valid_o,
  output job_t                   job_o,
  input  logic                   job_ready_i
);

  logic                   busy_q, done_q;
  logic [IDX_W-1:0]       k_q;
  logic signed [S_W-1:0]  s_q;
  logic [LANES-1:0][15:0] x_q;
  logic                   fin_q;
  logic signed [31:0]     prod;
  logic signed [S_W-1:0]  mag;
  logic [S_W-1:0]         a;

  assign prod = $signed(cfg_i.w_vec[16*k_q +: 16]) * $signed(x_q[k_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else if (!busy_q) begin
      if (push_i) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        k_q    <= '0;
        x_q    <= x_i;
        fin_q  <= fin_i;
        s_q    <= {{(S_W-28){cfg_i.bias[15]}}, cfg_i.bias, 12'b0};
      end
    end else if (!done_q) begin
      s_q <= s_q + S_W'(prod);
      if (k_q == IDX_W'(DIMS-1)) begin
        done_q <= 1'b1;
      end else begin
        k_q <= k_q + 1'b1;
      end
    end else if (job_ready_i) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end
  end

  always_comb begin
    mag = s_q[S_W-1] ? -s_q : s_q;
    a   = {mag[S_W-2:0], 1'b0};
    job_o.x   = x_q;
    job_o.fin = fin_q;
    job_o.neg = s_q[S_W-1];
    job_o.sat = (a[S_W-1:28] != '0);
    job_o.xq  = a[27:2];
  end

  assign job_valid_o = busy_q & done_q;
  assign full_o      = busy_q;

endmodule

// File: hdl/pff_fifo.sv
// Two-entry queue between front and back
module pff_fifo import pff_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  job_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output job_t rd_data_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_wr, do_rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign do_wr      = wr_valid_i & wr_ready_o;
  assign do_rd      = rd_ready_i & rd_valid_o;
  assign rd_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_q <= ~wr_ptr_q;
      if (do_rd) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

// File: hdl/pff_div.sv
// Restoring divider, one quotient bit a cycle
module pff_div import pff_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  logic             run_q, done_q;
  logic [5:0]       cnt_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] q_q;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, q_q[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
        rem_q <= '0;
        den_q <= den_i;
        q_q   <= num_i;
      end else if (run_q) begin
        rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
        q_q   <= {q_q[NUM_W-2:0], fits};
        if (cnt_q == 6'(NUM_W-1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

// File: hdl/pff_back.sv
// Back end: sequencer over one shared multiplier and the divider
module pff_back import pff_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic                   job_valid_i,
  output logic                   job_ready_o,
  input  job_t                   job_i,
  output logic                   empty_o,
  input  logic                   pop_i,
  output logic [LANES-1:0][15:0] y_o,
  output logic [23:0]            point_logdet_o,
  output logic [31:0]            logdet_total_o,
  output logic                   end_of_set_o
);

  localparam logic [4:0] ST_IDLE = 5'd0,  ST_UW_MUL = 5'd1,  ST_UW_ACC = 5'd2,
                         ST_EXP_MUL = 5'd3, ST_EXP_DIV = 5'd4,
                         ST_SQ_MUL = 5'd6,  ST_SQ_UPD = 5'd7,  ST_TANH_DIV = 5'd8,
                         ST_TANH_WAIT = 5'd9, ST_Y_MUL = 5'd10, ST_Y_UPD = 5'd11,
                         ST_TT_MUL = 5'd12, ST_TT_UPD = 5'd13, ST_DH_MUL = 5'd14,
                         ST_DH_UPD = 5'd15, ST_DL_MUL = 5'd16, ST_DL_UPD = 5'd17,
                         ST_NORM = 5'd18,   ST_LOG_MUL = 5'd19, ST_LOG_UPD = 5'd20,
                         ST_LN_MUL = 5'd21, ST_LN_UPD = 5'd22, ST_OUT = 5'd23;

  localparam logic [31:0] LN2_Q30 = 32'd744261118;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  // reciprocals for the Taylor divisors 3 and 5, exact for 27-bit dividends
  localparam logic [27:0] RCP3    = 28'd178956971;  // ceil(2^29/3)
  localparam logic [27:0] RCP5    = 28'd214748365;  // ceil(2^30/5)

  logic [4:0]             state_q;
  job_t                   job_q;
  logic [4:0]             k_q;
  logic [2:0]             i_q;
  logic signed [S_W-1:0]  uw_q;
  logic [30:0]            term_q, e_q;
  logic signed [17:0]     t_q;
  logic [LANES-1:0][15:0] y_q;
  logic [16:0]            dt_q;
  logic signed [37:0]     det_q;
  logic [33:0]            m_q;
  logic [5:0]             p_q;
  logic [19:0]            frac_q;
  logic signed [23:0]     ld_q;
  logic signed [31:0]     acc_q;
  logic signed [63:0]     prod_q;

  logic                   out_valid_q;
  logic [LANES-1:0][15:0] out_y_q;
  logic [23:0]            out_ld_q;
  logic [31:0]            out_tot_q;
  logic                   out_fin_q;

  logic [IDX_W-1:0]   k;
  logic signed [31:0] ma, mb;
  logic               div_start, div_done;
  logic [NUM_W-1:0]   div_num, div_quot;
  logic [DEN_W-1:0]   div_den;
  logic [30:0]        tv, e_upd;
  logic [26:0]        tv_num;
  logic [55:0]        tv_rcp;
  logic signed [33:0] yr_sum;
  logic signed [18:0] yv;
  logic [31:0]        sq;
  logic signed [37:0] det_full;
  logic [25:0]        floor_q24;
  logic signed [63:0] ln_sum;
  logic signed [29:0] ln_val;
  logic signed [32:0] acc_sum;
  logic signed [31:0] acc_next;
  logic               out_free;

  assign k = k_q[IDX_W-1:0];

  // operand select for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      ST_UW_MUL: begin
        ma = 32'($signed(cfg_i.u_vec[16*k +: 16]));
        mb = 32'($signed(cfg_i.w_vec[16*k +: 16]));
      end
      ST_EXP_MUL: begin
        ma = {1'b0, term_q};
        mb = {6'b0, job_q.xq};
      end
      ST_SQ_MUL:  begin ma = {1'b0, e_q}; mb = {1'b0, e_q}; end
      ST_Y_MUL:   begin ma = 32'($signed(cfg_i.u_vec[16*k +: 16])); mb = 32'(t_q); end
      ST_TT_MUL:  begin ma = 32'(t_q); mb = 32'(t_q); end
      ST_DH_MUL:  begin ma = {15'b0, dt_q}; mb = 32'($signed(uw_q[S_W-1:16])); end
      ST_DL_MUL:  begin ma = {15'b0, dt_q}; mb = {16'b0, uw_q[15:0]}; end
      ST_LOG_MUL: begin ma = {1'b0, m_q[30:0]}; mb = {1'b0, m_q[30:0]}; end
      ST_LN_MUL:  begin ma = 32'($signed({p_q - 6'd24, frac_q})); mb = LN2_Q30; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ma * mb;
  end

  // only the tanh quotient has a variable divisor
  always_comb begin
    div_start = (state_q == ST_TANH_DIV);
    div_num   = {31'(Q30_ONE - e_q), 16'b0} + NUM_W'((32'(Q30_ONE) + 32'(e_q)) >> 1);
    div_den   = 32'(Q30_ONE) + 32'(e_q);
  end

  pff_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    // Taylor term divided by its index: shifts for 2 and 4, reciprocals for 3 and 5
    tv_num   = prod_q[56:30];
    tv_rcp   = '0;
    case (i_q)
      3'd2:    tv = {5'b0, tv_num[26:1]};
      3'd3: begin
        tv_rcp = {29'b0, tv_num} * {28'b0, RCP3};
        tv     = 31'(tv_rcp >> 29);
      end
      3'd4:    tv = {6'b0, tv_num[26:2]};
      3'd5: begin
        tv_rcp = {29'b0, tv_num} * {28'b0, RCP5};
        tv     = 31'(tv_rcp >> 30);
      end
      default: tv = {4'b0, tv_num};
    endcase
    e_upd    = i_q[0] ? e_q - tv : e_q + tv;
    yr_sum   = $signed(prod_q[33:0]) + 34'sd32768;
    yv       = 19'($signed(job_q.x[k])) + 19'(yr_sum >>> 16);
    sq       = prod_q[61:30];
    det_full = 38'sd16777216 + det_q + 38'($signed({1'b0, prod_q[48:16]}));
    floor_q24 = {(cfg_i.det_floor == 16'd0) ? 16'd1 : cfg_i.det_floor, 10'b0};
    ln_sum   = prod_q + 64'sd8589934592;
    ln_val   = 30'(ln_sum >>> 34);
    acc_sum  = 33'(acc_q) + 33'(ld_q);
    if (acc_sum > 33'sd2147483647)       acc_next = 32'sh7FFF_FFFF;
    else if (acc_sum < -33'sd2147483648) acc_next = 32'sh8000_0000;
    else                                  acc_next = acc_sum[31:0];
    out_free = !out_valid_q || pop_i;
  end

  assign job_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      k_q         <= '0;
      i_q         <= 3'd1;
    end else begin
      if (pop_i && out_valid_q && state_q != ST_OUT) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            job_q   <= job_i;
            uw_q    <= '0;
            y_q     <= '0;
            k_q     <= '0;
            state_q <= ST_UW_MUL;
          end
        end
        ST_UW_MUL: state_q <= ST_UW_ACC;
        ST_UW_ACC: begin
          uw_q <= uw_q + S_W'($signed(prod_q[31:0]));
          if (k == IDX_W'(DIMS-1)) begin
            k_q <= '0;
            if (job_q.sat) begin
              t_q     <= job_q.neg ? -18'sd65536 : 18'sd65536;
              state_q <= ST_Y_MUL;
            end else begin
              i_q     <= 3'd1;
              term_q  <= Q30_ONE;
              e_q     <= Q30_ONE;
              state_q <= ST_EXP_MUL;
            end
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= ST_UW_MUL;
          end
        end
        ST_EXP_MUL: state_q <= ST_EXP_DIV;
        ST_EXP_DIV: begin
          term_q <= tv;
          e_q    <= e_upd;
          if (i_q == 3'd5) begin
            k_q     <= '0;
            state_q <= ST_SQ_MUL;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= ST_EXP_MUL;
          end
        end
        ST_SQ_MUL: state_q <= ST_SQ_UPD;
        ST_SQ_UPD: begin
          e_q <= 31'((prod_q + 64'sd536870912) >>> 30);
          if (k_q == 5'd7) begin
            state_q <= ST_TANH_DIV;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= ST_SQ_MUL;
          end
        end
        ST_TANH_DIV: state_q <= ST_TANH_WAIT;
        ST_TANH_WAIT: begin
          if (div_done) begin
            t_q     <= job_q.neg ? -$signed({1'b0, div_quot[16:0]})
                                 : $signed({1'b0, div_quot[16:0]});
            k_q     <= '0;
            state_q <= ST_Y_MUL;
          end
        end
        ST_Y_MUL: state_q <= ST_Y_UPD;
        ST_Y_UPD: begin
          if (yv > 19'sd32767)       y_q[k] <= 16'h7FFF;
          else if (yv < -19'sd32768) y_q[k] <= 16'h8000;
          else                       y_q[k] <= yv[15:0];
          if (k == IDX_W'(DIMS-1)) begin
            state_q <= ST_TT_MUL;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= ST_Y_MUL;
          end
        end
        ST_TT_MUL: state_q <= ST_TT_UPD;
        ST_TT_UPD: begin
          dt_q    <= 17'(33'd65536 - 33'(prod_q[48:16]));
          state_q <= ST_DH_MUL;
        end
        ST_DH_MUL: state_q <= ST_DH_UPD;
        ST_DH_UPD: begin
          det_q   <= 38'(prod_q);
          state_q <= ST_DL_MUL;
        end
        ST_DL_MUL: state_q <= ST_DL_UPD;
        ST_DL_UPD: begin
          if (det_full <= $signed({12'b0, floor_q24})) m_q <= {8'b0, floor_q24};
          else                                           m_q <= det_full[33:0];
          p_q     <= 6'd30;
          state_q <= ST_NORM;
        end
        ST_NORM: begin
          if (m_q[33:31] != 3'b0) begin
            m_q <= m_q >> 1;
            p_q <= p_q + 1'b1;
          end else if (!m_q[30]) begin
            m_q <= m_q << 1;
            p_q <= p_q - 1'b1;
          end else begin
            k_q     <= '0;
            frac_q  <= '0;
            state_q <= ST_LOG_MUL;
          end
        end
        ST_LOG_MUL: state_q <= ST_LOG_UPD;
        ST_LOG_UPD: begin
          frac_q <= {frac_q[18:0], sq[31]};
          m_q    <= sq[31] ? {3'b0, sq[31:1]} : {2'b0, sq};
          if (k_q == 5'd19) begin
            state_q <= ST_LN_MUL;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= ST_LOG_MUL;
          end
        end
        ST_LN_MUL: state_q <= ST_LN_UPD;
        ST_LN_UPD: begin
          if (ln_val > 30'sd8388607)       ld_q <= 24'sh7F_FFFF;
          else if (ln_val < -30'sd8388608) ld_q <= 24'sh80_0000;
          else                             ld_q <= ln_val[23:0];
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_y_q     <= y_q;
            out_ld_q    <= ld_q;
            out_tot_q   <= acc_next;
            out_fin_q   <= job_q.fin;
            acc_q       <= job_q.fin ? 32'sd0 : acc_next;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign empty_o        = !out_valid_q;
  assign y_o            = out_y_q;
  assign point_logdet_o = out_ld_q;
  assign logdet_total_o = out_tot_q;
  assign end_of_set_o   = out_fin_q;

endmodule

// File: hdl/planar_flow_forward_top.sv
// Top level of the planar flow forward block
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  point in | push / full           | x0_i..x3_i, final_point_i
//  result   | empty / pop           | y0_o..y3_o, point_logdet_o, logdet_total_o,
//           |                       | end_of_set_o
//  config   | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// A point takes longer in the back when tanh does not saturate than when it does,
// as a saturating point skips the exp series and the tanh division; the serial
// divider, the single shared multiplier and the log normalising loop dominate.
// The front forms w.x + b lane by lane and can take the next point while the
// back works; a two-entry queue and an output register decouple the stages.
// rst_ni is asynchronous and clears control state and the logdet total.
// Without a pop the output register holds its result and the back waits in its last step.
module planar_flow_forward_top import pff_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] x0_i,
  input  logic [15:0] x1_i,
  input  logic [15:0] x2_i,
  input  logic [15:0] x3_i,
  input  logic        final_point_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] y0_o,
  output logic [15:0] y1_o,
  output logic [15:0] y2_o,
  output logic [15:0] y3_o,
  output logic [23:0] point_logdet_o,
  output logic [31:0] logdet_total_o,
  output logic        end_of_set_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  cfg_t                   cfg_q;
  logic [LANES-1:0][15:0] x_vec, y_vec;
  logic                   f_valid, f_ready, b_valid, b_ready;
  job_t                   f_job, b_job;

  // config writes are always taken; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.u_vec     <= '0;
      cfg_q.w_vec     <= '0;
      cfg_q.bias      <= '0;
      cfg_q.det_floor <= 16'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_U_VEC:     cfg_q.u_vec     <= cfg_data_i;
        REG_W_VEC:     cfg_q.w_vec     <= cfg_data_i;
        REG_BIAS:      cfg_q.bias      <= cfg_data_i[15:0];
        REG_DET_FLOOR: cfg_q.det_floor <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign x_vec = {x3_i, x2_i, x1_i, x0_i};

  pff_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .x_i         (x_vec),
    .fin_i       (final_point_i),
    .cfg_i       (cfg_q),
    .job_valid_o (f_valid),
    .job_o       (f_job),
    .job_ready_i (f_ready)
  );

  pff_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (f_job),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (b_job)
  );

  pff_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .job_valid_i    (b_valid),
    .job_ready_o    (b_ready),
    .job_i          (b_job),
    .empty_o        (empty),
    .pop_i          (pop),
    .y_o            (y_vec),
    .point_logdet_o (point_logdet_o),
    .logdet_total_o (logdet_total_o),
    .end_of_set_o   (end_of_set_o)
  );

  assign y0_o = y_vec[0];
  assign y1_o = y_vec[1];
  assign y2_o = y_vec[2];
  assign y3_o = y_vec[3];

endmodule

// File: hdl/pff_checker.sv
// Port-level checker for the planar flow block, bound to the top level
`include "planar_flow_forward_top_defines.svh"

module pff_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic        pop,
  input logic        empty,
  input logic [23:0] point_logdet_o,
  input logic [31:0] logdet_total_o,
  input logic        end_of_set_o
);

  logic [2:0] inflight_q;
  logic       set_start_q;

  // set_start_q: the shown result opens a new point set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q  <= '0;
      set_start_q <= 1'b1;
    end else begin
      inflight_q <= inflight_q + {2'b0, push & ~full} - {2'b0, pop & ~empty};
      if (pop && !empty) set_start_q <= end_of_set_o;
    end
  end

  `PFF_ASSERT_NEXT(a_result_held, !empty && !pop, !empty, "result dropped without pop")
  `PFF_ASSERT_NEXT(a_total_held, !empty && !pop, $stable(logdet_total_o), "total changed under stall")
  `PFF_ASSERT_IMPL(a_capacity, 1'b1, inflight_q <= 3'd5, "more transactions in flight than storage")
  `PFF_ASSERT_IMPL(a_set_start, !empty && set_start_q, $signed(logdet_total_o) == $signed(point_logdet_o), "total not restarted after end of set")

endmodule

bind planar_flow_forward_top pff_checker u_pff_checker (.*);
